@@ src/assert_macros.svh @@
// Assertion helpers shared by the frame packer RTL.
// MCFP_ASSERT is masked while reset is asserted; MCFP_ASSERT_RST also checks during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MCFP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MCFP_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MCFP_ASSERT(lbl, clk, rst_n, prop, msg)
`define MCFP_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

@@ src/mcfp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package mcfp_pkg;

  localparam int IN_W   = 32;
  localparam int LIM_W  = 21;
  localparam int ID_W   = 11;
  localparam int LEN_W  = 4;
  localparam int PAY_W  = 64;
  localparam int IDX_W  = 2;

  localparam int ANGLE_BITS = 16;
  localparam int GAIN_BITS  = 12;

  // Scaled value after the (span / 2^frac) step, and reciprocal for the divide-by-span.
  localparam int XW  = 21;
  localparam int MW  = 28;
  localparam int MSH = 30;

  // Pipeline stages
  localparam int NS        = 5;
  localparam int ST_CLAMP  = 0;
  localparam int ST_LIMIT  = 1;
  localparam int ST_SCALE  = 2;
  localparam int ST_DIV    = 3;
  localparam int ST_OUT    = 4;

  localparam logic [LEN_W-1:0] FRAME_LEN = 4'd8;

  localparam logic signed [LIM_W-1:0] LIM_LO_RESET = -21'sd819200;
  localparam logic signed [LIM_W-1:0] LIM_HI_RESET = 21'sd819200;
  localparam logic [ID_W-1:0]         CAN_ID_RESET = 11'd1;

  typedef enum logic [IDX_W-1:0] {
    REG_ANGLE_LO = 2'd0,
    REG_ANGLE_HI = 2'd1,
    REG_CAN_ID   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [LIM_W-1:0] lim_lo;
    logic signed [LIM_W-1:0] lim_hi;
    logic [ID_W-1:0]         can_id;
  } cfg_t;

  typedef struct packed {
    logic [NS-1:0] en;
    logic [NS-1:0] valid;
  } pipe_ctl_t;

endpackage
`default_nettype wire

@@ src/mcfp_cfg_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface mcfp_cfg_if;
  import mcfp_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [LIM_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ src/mcfp_cmd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface mcfp_cmd_if;
  import mcfp_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] angle_cmd;
  logic signed [IN_W-1:0] target_speed;
  logic signed [IN_W-1:0] stiffness;
  logic signed [IN_W-1:0] damping;
  logic signed [IN_W-1:0] feed_torque;

  modport source (
    output valid, output angle_cmd, output target_speed, output stiffness,
    output damping, output feed_torque, input ready
  );
  modport sink (
    input valid, input angle_cmd, input target_speed, input stiffness,
    input damping, input feed_torque, output ready
  );
endinterface
`default_nettype wire

@@ src/mcfp_frame_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface mcfp_frame_if;
  import mcfp_pkg::*;

  logic             valid;
  logic             ready;
  logic [ID_W-1:0]  frame_id;
  logic [PAY_W-1:0] frame_payload;
  logic [LEN_W-1:0] frame_length;

  modport source (
    output valid, output frame_id, output frame_payload, output frame_length, input ready
  );
  modport sink (
    input valid, input frame_id, input frame_payload, input frame_length, output ready
  );
endinterface
`default_nettype wire

@@ src/mcfp_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mcfp_cfg_regs (
  input  wire logic         clk,
  input  wire logic         rst_n,
  mcfp_cfg_if.sink          cfg_wr,
  output mcfp_pkg::cfg_t    cfg
);
  import mcfp_pkg::*;

  cfg_t cfg_r;

  assign cfg_wr.ready = 1'b1;
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lim_lo <= LIM_LO_RESET;
      cfg_r.lim_hi <= LIM_HI_RESET;
      cfg_r.can_id <= CAN_ID_RESET;
    end else if (cfg_wr.valid) begin
      case (cfg_reg_t'(cfg_wr.index))
        REG_ANGLE_LO: cfg_r.lim_lo <= cfg_wr.data;
        REG_ANGLE_HI: cfg_r.lim_hi <= cfg_wr.data;
        REG_CAN_ID:   cfg_r.can_id <= cfg_wr.data[ID_W-1:0];
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ src/mcfp_pipe_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mcfp_pipe_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic            out_ready,
  output mcfp_pkg::pipe_ctl_t  ctl
);
  import mcfp_pkg::*;

  logic [NS-1:0] v_r;
  logic [NS-1:0] v_nxt;
  logic [NS-1:0] rdy;

  // A stage can load when it is empty or its word moves on this cycle.
  always_comb begin
    rdy[NS-1] = !v_r[NS-1] || out_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  always_comb begin
    v_nxt[0] = rdy[0] ? in_valid : v_r[0];
    for (int i = 1; i < NS; i++) begin
      v_nxt[i] = rdy[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = rdy[0];
  assign ctl.en    = rdy;
  assign ctl.valid = v_r;

  `MCFP_ASSERT_RST(a_rst_clears, clk, !rst_n |=> (v_r == '0), "pipeline valid bits not cleared")
  `MCFP_ASSERT(a_full_blocks, clk, rst_n, ((&v_r) && !out_ready) |-> !in_ready, "accepted into a full stalled pipe")
  `MCFP_ASSERT(a_accept_lands, clk, rst_n, (in_valid && in_ready) |=> v_r[0], "accepted word missing from first stage")
  `MCFP_ASSERT(a_stall_holds, clk, rst_n, (v_r[NS-1] && !out_ready && v_r[NS-2]) |=> (v_r[NS-1] && v_r[NS-2]), "stalled word lost")

endmodule
`default_nettype wire

@@ src/mcfp_quant_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mcfp_quant_lane #(
  parameter int FRAC_BITS = 16,
  parameter int LO_HALF   = -25,
  parameter int HI_HALF   = 25,
  parameter int BITS      = 16,
  parameter int LIMIT_EN  = 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire mcfp_pkg::pipe_ctl_t               ctl,
  input  wire logic signed [mcfp_pkg::IN_W-1:0]  din,
  input  wire logic signed [mcfp_pkg::LIM_W-1:0] lim_lo,
  input  wire logic signed [mcfp_pkg::LIM_W-1:0] lim_hi,
  output logic [BITS-1:0]                        code
);
  import mcfp_pkg::*;

  // Bounds are LO_HALF / HI_HALF halves of one unit; the span is K whole units.
  localparam int     CW   = (FRAC_BITS + 11 > 34) ? FRAC_BITS + 11 : 34;
  localparam longint LO_L = longint'(LO_HALF) * (longint'(1) << (FRAC_BITS - 1));
  localparam longint HI_L = longint'(HI_HALF) * (longint'(1) << (FRAC_BITS - 1));
  localparam int     K    = (HI_HALF - LO_HALF) / 2;
  localparam int     PW   = CW + BITS;

  localparam logic signed [CW-1:0] LO   = CW'(LO_L);
  localparam logic signed [CW-1:0] HI   = CW'(HI_L);
  localparam logic signed [CW-1:0] SPAN = CW'(longint'(K) << FRAC_BITS);
  localparam logic [BITS-1:0]      TOP  = '1;
  localparam logic [MW-1:0]        M    =
    MW'(((longint'(1) << MSH) + longint'(K) - 1) / longint'(K));
  localparam logic [XW-1:0]        XMAX = XW'(longint'(K) * ((longint'(1) << BITS) - 1));

  logic signed [CW-1:0] din_ext;
  logic signed [CW-1:0] a_nxt;
  logic signed [CW-1:0] a_r;
  logic signed [CW-1:0] lim_lo_ext;
  logic signed [CW-1:0] lim_hi_ext;
  logic signed [CW-1:0] b;
  logic signed [CW-1:0] d_nxt;
  logic signed [CW-1:0] d_r;
  logic [PW-1:0]        d_wide;
  logic [PW-1:0]        p;
  logic [XW-1:0]        x_nxt;
  logic [XW-1:0]        x_r;
  logic                 zero_nxt;
  logic                 full_nxt;
  logic                 zero_r;
  logic                 full_r;
  logic [XW+MW-1:0]     prod;
  logic [BITS-1:0]      code_nxt;
  logic [BITS-1:0]      code_r;

  // Stage 0: clamp to the fixed range.
  always_comb begin
    din_ext = {{(CW-IN_W){din[IN_W-1]}}, din};
    if (din_ext < LO) begin
      a_nxt = LO;
    end else if (din_ext > HI) begin
      a_nxt = HI;
    end else begin
      a_nxt = din_ext;
    end
  end

  // Stage 1: joint limits when LIMIT_EN is set (low limit wins), then offset from the range floor.
  always_comb begin
    lim_lo_ext = {{(CW-LIM_W){lim_lo[LIM_W-1]}}, lim_lo};
    lim_hi_ext = {{(CW-LIM_W){lim_hi[LIM_W-1]}}, lim_hi};
    b = a_r;
    if (LIMIT_EN != 0) begin
      if (a_r < lim_lo_ext) begin
        b = lim_lo_ext;
      end else if (a_r > lim_hi_ext) begin
        b = lim_hi_ext;
      end
    end
    d_nxt = b - LO;
  end

  // Stage 2: saturation flags and d * (2^BITS - 1) / 2^FRAC_BITS.
  always_comb begin
    zero_nxt = (d_r <= 0);
    full_nxt = (d_r >= SPAN);
    d_wide   = {{BITS{1'b0}}, d_r};
    p        = (d_wide << BITS) - d_wide;
    x_nxt    = p[FRAC_BITS +: XW];
  end

  // Stage 3: divide by K through the reciprocal; exact over the range of x.
  always_comb begin
    prod = {{MW{1'b0}}, x_r} * {{XW{1'b0}}, M};
    if (full_r) begin
      code_nxt = TOP;
    end else if (zero_r) begin
      code_nxt = '0;
    end else begin
      code_nxt = prod[MSH +: BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[ST_CLAMP]) begin
      a_r <= a_nxt;
    end
    if (ctl.en[ST_LIMIT]) begin
      d_r <= d_nxt;
    end
    if (ctl.en[ST_SCALE]) begin
      x_r    <= x_nxt;
      zero_r <= zero_nxt;
      full_r <= full_nxt;
    end
    if (ctl.en[ST_DIV]) begin
      code_r <= code_nxt;
    end
  end

  assign code = code_r;

  `MCFP_ASSERT(a_clamp_range, clk, rst_n, ctl.valid[ST_CLAMP] |-> ((a_r >= LO) && (a_r <= HI)), "clamp stage out of range")
  `MCFP_ASSERT(a_sat_excl, clk, rst_n, ctl.valid[ST_SCALE] |-> !(zero_r && full_r), "both saturation flags set")
  `MCFP_ASSERT(a_scale_bound, clk, rst_n, (ctl.valid[ST_SCALE] && !zero_r && !full_r) |-> (x_r < XMAX), "scaled value past reciprocal range")

endmodule
`default_nettype wire

@@ src/mit_command_frame_packer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Impedance-mode motor command packer. Each command word (angle, speed, stiffness,
// damping, feed-forward torque, all signed Q16.16 by default) is clamped, quantized
// to 16 bits (angle) or 12 bits (the rest) as floor((x-min)*(2^bits-1)/(max-min)),
// and packed big-endian into an 8-byte CAN payload sent with the configured
// identifier. The block takes one command word every cycle unless the output stalls;
// each word passes through five register stages (range clamp, joint-limit clamp and
// offset, scale, reciprocal multiply for the divide, output register) before its frame
// is returned. Stages advance independently, so bubbles close up behind a stalled
// output and the input keeps accepting until every stage holds a word. Write the
// joint limits and CAN identifier only while no command is in flight; reset loads
// limits of -12.5 and +12.5 in Q16.16 and identifier 1, and needs no clearing time.
module mit_command_frame_packer #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  mcfp_cfg_if.sink      cfg_wr,
  mcfp_cmd_if.sink      in_cmd,
  mcfp_frame_if.source  out_frame
);
  import mcfp_pkg::*;

  cfg_t                  cfg;
  pipe_ctl_t             ctl;
  logic [ANGLE_BITS-1:0] pos_code;
  logic [GAIN_BITS-1:0]  spd_code;
  logic [GAIN_BITS-1:0]  kp_code;
  logic [GAIN_BITS-1:0]  kd_code;
  logic [GAIN_BITS-1:0]  tq_code;
  logic [PAY_W-1:0]      payload_nxt;
  logic [PAY_W-1:0]      payload_r;

  // Joint limits and CAN identifier
  mcfp_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .cfg    (cfg)
  );

  // Valid bits and per-stage load enables
  mcfp_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_cmd.valid),
    .in_ready  (in_cmd.ready),
    .out_ready (out_frame.ready),
    .ctl       (ctl)
  );

  // Angle: +-12.5, then the joint limits
  mcfp_quant_lane #(
    .FRAC_BITS (FRAC_BITS), .LO_HALF (-25), .HI_HALF (25),
    .BITS (ANGLE_BITS), .LIMIT_EN (1)
  ) u_pos (
    .clk (clk), .rst_n (rst_n), .ctl (ctl), .din (in_cmd.angle_cmd),
    .lim_lo (cfg.lim_lo), .lim_hi (cfg.lim_hi), .code (pos_code)
  );

  // Speed: +-45
  mcfp_quant_lane #(
    .FRAC_BITS (FRAC_BITS), .LO_HALF (-90), .HI_HALF (90),
    .BITS (GAIN_BITS), .LIMIT_EN (0)
  ) u_spd (
    .clk (clk), .rst_n (rst_n), .ctl (ctl), .din (in_cmd.target_speed),
    .lim_lo (cfg.lim_lo), .lim_hi (cfg.lim_hi), .code (spd_code)
  );

  // Stiffness: 0..500
  mcfp_quant_lane #(
    .FRAC_BITS (FRAC_BITS), .LO_HALF (0), .HI_HALF (1000),
    .BITS (GAIN_BITS), .LIMIT_EN (0)
  ) u_kp (
    .clk (clk), .rst_n (rst_n), .ctl (ctl), .din (in_cmd.stiffness),
    .lim_lo (cfg.lim_lo), .lim_hi (cfg.lim_hi), .code (kp_code)
  );

  // Damping: 0..5
  mcfp_quant_lane #(
    .FRAC_BITS (FRAC_BITS), .LO_HALF (0), .HI_HALF (10),
    .BITS (GAIN_BITS), .LIMIT_EN (0)
  ) u_kd (
    .clk (clk), .rst_n (rst_n), .ctl (ctl), .din (in_cmd.damping),
    .lim_lo (cfg.lim_lo), .lim_hi (cfg.lim_hi), .code (kd_code)
  );

  // Feed-forward torque: +-18
  mcfp_quant_lane #(
    .FRAC_BITS (FRAC_BITS), .LO_HALF (-36), .HI_HALF (36),
    .BITS (GAIN_BITS), .LIMIT_EN (0)
  ) u_tq (
    .clk (clk), .rst_n (rst_n), .ctl (ctl), .din (in_cmd.feed_torque),
    .lim_lo (cfg.lim_lo), .lim_hi (cfg.lim_hi), .code (tq_code)
  );

  // Pack big-endian: angle in the top 16 bits, then speed, stiffness, damping, torque.
  assign payload_nxt = {pos_code, spd_code, kp_code, kd_code, tq_code};

  // Output register; hold the word while the sink stalls.
  always_ff @(posedge clk) begin
    if (ctl.en[ST_OUT]) begin
      payload_r <= payload_nxt;
    end
  end

  // Users rewrite the identifier only with the pipe empty (unchecked); frame_id reads the register.
  assign out_frame.valid         = ctl.valid[ST_OUT];
  assign out_frame.frame_payload = payload_r;
  assign out_frame.frame_id      = cfg.can_id;
  assign out_frame.frame_length  = FRAME_LEN;

endmodule
`default_nettype wire

@@ tb/sv/frame_packing_checker.sv @@
`timescale 1ns / 1ps
module frame_packing_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  mcfp_cfg_if   cfg_bus,
  mcfp_cmd_if   cmd_bus,
  mcfp_frame_if frame_bus,
  output int    mismatches,
  output int    outstanding,
  output int    frames_seen
);
  import mcfp_pkg::*;

  localparam longint ANGLE_HALF = longint'(25) <<< (FRAC_BITS - 1);
  localparam longint SPEED_MAX  = longint'(45) <<< FRAC_BITS;
  localparam longint STIFF_MAX  = longint'(500) <<< FRAC_BITS;
  localparam longint DAMP_MAX   = longint'(5) <<< FRAC_BITS;
  localparam longint TORQUE_MAX = longint'(18) <<< FRAC_BITS;
  localparam logic [LEN_W-1:0] PAYLOAD_BYTES = 4'd8;

  typedef struct {
    logic [ID_W-1:0]  id;
    logic [PAY_W-1:0] payload;
    logic [LEN_W-1:0] len;
  } frame_t;

  frame_t          pending_frames[$];
  longint          lim_lo;
  longint          lim_hi;
  logic [ID_W-1:0] can_id;

  function automatic longint clip(longint x, longint lo, longint hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  // floor((x-lo)*(2^bits-1)/(hi-lo)), saturated to the code range
  function automatic longint quant(longint x, longint lo, longint hi, int bits);
    longint top_code;
    longint span;
    longint d;
    top_code = (longint'(1) <<< bits) - 1;
    span = hi - lo;
    d = x - lo;
    if (d <= 0) return 0;
    if (d >= span) return top_code;
    return (d * top_code) / span;
  endfunction

  function automatic frame_t pack_command(
    input logic signed [IN_W-1:0] ang_in, spd_in, kp_in, kd_in, tq_in
  );
    frame_t f;
    longint ang;
    longint pc, vc, kpc, kdc, tc;
    ang = clip(longint'(ang_in), -ANGLE_HALF, ANGLE_HALF);
    ang = clip(ang, lim_lo, lim_hi);
    pc  = quant(ang, -ANGLE_HALF, ANGLE_HALF, ANGLE_BITS);
    vc  = quant(clip(longint'(spd_in), -SPEED_MAX, SPEED_MAX), -SPEED_MAX, SPEED_MAX,
                GAIN_BITS);
    kpc = quant(clip(longint'(kp_in), 0, STIFF_MAX), 0, STIFF_MAX, GAIN_BITS);
    kdc = quant(clip(longint'(kd_in), 0, DAMP_MAX), 0, DAMP_MAX, GAIN_BITS);
    tc  = quant(clip(longint'(tq_in), -TORQUE_MAX, TORQUE_MAX), -TORQUE_MAX, TORQUE_MAX,
                GAIN_BITS);
    f.id      = can_id;
    f.payload = {pc[15:0], vc[11:0], kpc[11:0], kdc[11:0], tc[11:0]};
    f.len     = PAYLOAD_BYTES;
    return f;
  endfunction

  task automatic check_field(input string name, input logic [PAY_W-1:0] want,
                             input logic [PAY_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    frame_t want;
    if (!rst_n) begin
      lim_lo = longint'(LIM_LO_RESET);
      lim_hi = longint'(LIM_HI_RESET);
      can_id = CAN_ID_RESET;
      pending_frames.delete();
      mismatches  = 0;
      frames_seen = 0;
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          REG_ANGLE_LO: lim_lo = longint'($signed(cfg_bus.data));
          REG_ANGLE_HI: lim_hi = longint'($signed(cfg_bus.data));
          REG_CAN_ID:   can_id = cfg_bus.data[ID_W-1:0];
          default: ;
        endcase
      end
      if (cmd_bus.valid && cmd_bus.ready)
        pending_frames.push_back(pack_command(cmd_bus.angle_cmd, cmd_bus.target_speed,
                                              cmd_bus.stiffness, cmd_bus.damping,
                                              cmd_bus.feed_torque));
      if (frame_bus.valid && frame_bus.ready) begin
        frames_seen++;
        if (pending_frames.size() == 0) begin
          $display("%0t: unexpected frame, expected none, got id %h payload %h", $time,
                   frame_bus.frame_id, frame_bus.frame_payload);
          mismatches++;
        end else begin
          want = pending_frames.pop_front();
          check_field("frame_id", PAY_W'(want.id), PAY_W'(frame_bus.frame_id));
          check_field("frame_payload", want.payload, frame_bus.frame_payload);
          check_field("frame_length", PAY_W'(want.len), PAY_W'(frame_bus.frame_length));
        end
      end
    end
    outstanding = pending_frames.size();
  end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import mcfp_pkg::*;

  localparam int FRAC = 16;
  // Longest quiet stretch allowed: the output hold-off plus pipeline and margin.
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int WORDS_PER_PHASE = 116;
  localparam int PHASES = 8;

  // Register index with no register behind it; writes to it must be dropped.
  localparam logic [IDX_W-1:0] REG_UNMAPPED = 2'd3;

  // Clamp bounds in the input fixed-point format.
  localparam int ANG_MAX = 25 << (FRAC - 1);
  localparam int SPD_MAX = 45 << FRAC;
  localparam int KP_MAX  = 500 << FRAC;
  localparam int KD_MAX  = 5 << FRAC;
  localparam int TQ_MAX  = 18 << FRAC;
  localparam int LIM_MIN = -(1 << (LIM_W - 1));
  localparam int LIM_TOP = (1 << (LIM_W - 1)) - 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  int idle_pct = 0;      // chance per cycle that the sender holds back
  int stall_pct = 0;     // chance per cycle that the receiver drops ready
  bit hold_off = 1'b0;   // long output stall, driven by its own process
  int words_sent = 0;
  int quiet_cycles = 0;
  int lim_lo_now = -819200;  // current limits, used only to aim stimulus
  int lim_hi_now = 819200;

  int mismatches;
  int outstanding;
  int frames_seen;

  mcfp_cfg_if   cfg_bus();
  mcfp_cmd_if   cmd_bus();
  mcfp_frame_if frame_bus();

  mit_command_frame_packer #(.FRAC_BITS(FRAC)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_bus.sink),
    .in_cmd    (cmd_bus.sink),
    .out_frame (frame_bus.source)
  );

  frame_packing_checker #(.FRAC_BITS(FRAC)) packing_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_bus     (cfg_bus),
    .cmd_bus     (cmd_bus),
    .frame_bus   (frame_bus),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .frames_seen (frames_seen)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: restart the count on any accepted word, give up when it runs out.
  always @(posedge clk) begin
    if (!rst_n || (cmd_bus.valid && cmd_bus.ready) || (frame_bus.valid && frame_bus.ready)
        || (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: drop ready at random per the current stall rate, or hold it low
  // for the whole hold-off window.
  initial begin
    frame_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      frame_bus.ready = !hold_off && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Pick a value around [lo, hi]: anything at all, a bound give or take one,
  // or a point inside the range with a little overshoot on each side.
  function automatic logic signed [IN_W-1:0] pick(longint lo, longint hi);
    int     sel;
    longint m;
    longint v;
    longint t;
    if (lo > hi) begin
      t = lo;
      lo = hi;
      hi = t;
    end
    sel = $urandom_range(0, 11);
    m = (hi - lo) / 8 + 1;
    case (sel)
      0, 1:    v = longint'(int'($urandom));
      2:       v = lo + longint'($urandom_range(0, 2)) - 1;
      3:       v = hi + longint'($urandom_range(0, 2)) - 1;
      default: v = lo - m + longint'($urandom_range(0, 32'(hi - lo + 2 * m)));
    endcase
    return v[IN_W-1:0];
  endfunction

  // Offer one command word, idling first as the sender rate says; return
  // at the falling edge after it was taken.
  task automatic send_word(input logic signed [IN_W-1:0] ang, spd, kp, kd, tq);
    while ($urandom_range(0, 99) < idle_pct) begin
      cmd_bus.valid = 1'b0;
      @(negedge clk);
    end
    cmd_bus.valid        = 1'b1;
    cmd_bus.angle_cmd    = ang;
    cmd_bus.target_speed = spd;
    cmd_bus.stiffness    = kp;
    cmd_bus.damping      = kd;
    cmd_bus.feed_torque  = tq;
    do @(posedge clk); while (!cmd_bus.ready);
    @(negedge clk);
    words_sent++;
  endtask

  // All five fields at their low or high clamp bound, shifted by offset.
  task automatic send_edge(input bit high, input int offset);
    send_word((high ? ANG_MAX : -ANG_MAX) + offset, (high ? SPD_MAX : -SPD_MAX) + offset,
              (high ? KP_MAX : 0) + offset, (high ? KD_MAX : 0) + offset,
              (high ? TQ_MAX : -TQ_MAX) + offset);
  endtask

  task automatic send_random_word();
    logic signed [IN_W-1:0] ang;
    // Aim half the angles at the joint limits, the rest at the +-12.5 clamp.
    if ($urandom_range(0, 1)) ang = pick(lim_lo_now, lim_hi_now);
    else ang = pick(-ANG_MAX, ANG_MAX);
    send_word(ang, pick(-SPD_MAX, SPD_MAX), pick(0, KP_MAX), pick(0, KD_MAX),
              pick(-TQ_MAX, TQ_MAX));
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [LIM_W-1:0] val);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = val;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
    if (idx == REG_ANGLE_LO) lim_lo_now = int'($signed(val));
    if (idx == REG_ANGLE_HI) lim_hi_now = int'($signed(val));
  endtask

  task automatic set_limits(input int lo, input int hi, input int id);
    write_reg(REG_ANGLE_LO, lo[LIM_W-1:0]);
    write_reg(REG_ANGLE_HI, hi[LIM_W-1:0]);
    write_reg(REG_CAN_ID, id[LIM_W-1:0]);
  endtask

  // Random limits over the whole register range; keep them ordered most of the time.
  task automatic random_limits();
    int a;
    int b;
    int t;
    a = int'($urandom_range(0, LIM_TOP - LIM_MIN)) + LIM_MIN;
    b = int'($urandom_range(0, LIM_TOP - LIM_MIN)) + LIM_MIN;
    if (a > b && $urandom_range(0, 3) != 0) begin
      t = a;
      a = b;
      b = t;
    end
    set_limits(a, b, $urandom_range(0, 2047));
  endtask

  // Stop offering and wait until every predicted frame has come back.
  task automatic drain();
    cmd_bus.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    cmd_bus.valid        = 1'b0;
    cmd_bus.angle_cmd    = '0;
    cmd_bus.target_speed = '0;
    cmd_bus.stiffness    = '0;
    cmd_bus.damping      = '0;
    cmd_bus.feed_torque  = '0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.index        = REG_ANGLE_LO;
    cfg_bus.data         = '0;

    // Hold reset, then release it at a falling edge.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed words under the reset register values: zero, the extremes of
    // the 32-bit fields, every clamp bound and its neighbors, bit patterns.
    send_word(0, 0, 0, 0, 0);
    send_word(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_word(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    send_edge(1'b0, 0);
    send_edge(1'b1, 0);
    send_edge(1'b0, -1);
    send_edge(1'b1, 1);
    send_edge(1'b0, 1);
    send_edge(1'b1, -1);
    send_word(32'h55555555, 32'h55555555, 32'h55555555, 32'h55555555, 32'h55555555);
    send_word(32'hAAAAAAAA, 32'hAAAAAAAA, 32'hAAAAAAAA, 32'hAAAAAAAA, 32'hAAAAAAAA);
    send_word(-1, -1, -1, -1, -1);
    drain();

    // Crossed limits: below low takes low first, even when low is above high.
    // Slip in a write to the unmapped index; it must change nothing.
    set_limits(100000, -100000, 0);
    write_reg(REG_UNMAPPED, '1);
    send_word(-200000, 0, 0, 0, 0);
    send_word(200000, 0, 0, 0, 0);
    send_word(0, 0, 0, 0, 0);
    send_word(100000, 0, 0, 0, 0);
    send_word(-100000, 0, 0, 0, 0);
    drain();

    // Limits past +-12.5 pull the angle out of range; the code saturates.
    set_limits(LIM_TOP, LIM_TOP, 2047);
    send_word(0, 0, 0, 0, 0);
    send_word(32'h80000000, 0, 0, 0, 0);
    drain();
    set_limits(LIM_MIN, LIM_MIN, 1);
    send_word(32'h7FFFFFFF, 0, 0, 0, 0);
    drain();

    // Random phases: a fresh register setting each, cycling the idle patterns.
    for (int p = 0; p < PHASES; p++) begin
      idle_pct  = 0;
      stall_pct = 0;
      case (p)
        0: set_limits(-ANG_MAX, ANG_MAX, 2047);
        2: set_limits(LIM_MIN, LIM_TOP, 0);
        4: set_limits(-ANG_MAX / 2, ANG_MAX / 2, 1);
        6: set_limits(-1, 1, 1365);
        default: random_limits();
      endcase
      case (p % 4)
        1: idle_pct = 64;
        2: stall_pct = 64;
        3: begin
          idle_pct  = 23;
          stall_pct = 23;
        end
        default: ;
      endcase
      // Back-pressure: freeze the output while the sender keeps pushing,
      // so every stage fills and the input stalls.
      if (p == 4) begin
        fork
          begin
            @(posedge clk);
            hold_off = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      repeat (WORDS_PER_PHASE) send_random_word();
      drain();
    end

    // Let the pipeline settle past its latency before the verdict.
    repeat (10) @(negedge clk);
    $display("Covered %0d command words and %0d frames over directed bounds, crossed",
             words_sent, frames_seen);
    $display("and out-of-range limits, %0d random settings, idle/stall mixes, %0d-cycle hold.",
             PHASES, HOLD_CYCLES);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
